[sv/tihp_pkg.sv]
package tihp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h16;
  localparam logic [7:0] MARKER_BYTE = 8'h24;
  localparam logic [7:0] NAME_END    = 8'h00;
  localparam logic [7:0] KIND_BASIC  = 8'h00;
  localparam logic [7:0] AUTO_BASIC  = 8'h80;

  localparam logic [7:0]  MIN_SYNC_RST     = 8'd3;
  localparam logic [15:0] BASIC_LEADER_RST = 16'd192;
  localparam logic [15:0] CODE_LEADER_RST  = 16'd112;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SYNC     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIC_LEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LEADER  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW_SYNC  = 2'd1;
  localparam logic [1:0] ST_NO_MARKER = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_FIELDS = 2'd1;
  localparam logic [1:0] PH_NAME   = 2'd2;

  // field step indexes after the marker
  localparam logic [3:0] STEP_KIND     = 4'd2;
  localparam logic [3:0] STEP_AUTO     = 4'd3;
  localparam logic [3:0] STEP_END_HI   = 4'd4;
  localparam logic [3:0] STEP_END_LO   = 4'd5;
  localparam logic [3:0] STEP_START_HI = 4'd6;
  localparam logic [3:0] STEP_START_LO = 4'd7;
  localparam logic [3:0] STEP_LAST     = 4'd8;

  typedef struct packed {
    logic [7:0]  min_sync;
    logic [15:0] basic_leader;
    logic [15:0] code_leader;
  } tihp_cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  file_kind;
    logic [7:0]  autorun_flag;
    logic [15:0] load_start;
    logic [15:0] load_end;
    logic [31:0] body_length;
    logic [15:0] leader_pad;
    logic        basic_file;
    logic [15:0] sync_found;
    logic [15:0] name_length;
    logic [15:0] header_length;
  } hdr_result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

[sv/tihp_in_if.sv]
interface tihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;
  logic       tape_end;

  modport source (output valid, output tape_byte, output tape_end, input ready);
  modport sink   (input valid, input tape_byte, input tape_end, output ready);
endinterface

[sv/tihp_out_if.sv]
interface tihp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  file_kind;
  logic [7:0]  autorun_flag;
  logic [15:0] load_start;
  logic [15:0] load_end;
  logic [31:0] body_length;
  logic [15:0] leader_pad;
  logic        basic_file;
  logic [15:0] sync_found;
  logic [15:0] name_length;
  logic [15:0] header_length;

  modport source (
    output valid, input ready,
    output status, output file_kind, output autorun_flag, output load_start,
    output load_end, output body_length, output leader_pad, output basic_file,
    output sync_found, output name_length, output header_length
  );
  modport sink (
    input valid, output ready,
    input status, input file_kind, input autorun_flag, input load_start,
    input load_end, input body_length, input leader_pad, input basic_file,
    input sync_found, input name_length, input header_length
  );
endinterface

[sv/tihp_cfg_if.sv]
interface tihp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tihp_core.sv]
module tihp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           tape_byte,
  input  logic                 tape_end,
  input  tihp_pkg::tihp_cfg_t  cfg,
  output logic                 emit,
  output tihp_pkg::hdr_result_t result
);
  import tihp_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] sync_r, sync_nxt;
  logic [3:0]  fstep_r, fstep_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  auto_r, auto_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] end_r, end_nxt;
  logic [15:0] namecnt_r, namecnt_nxt;
  logic [15:0] len_r, len_nxt;

  logic        basic;
  logic [15:0] want;
  logic [15:0] len_inc;
  logic        emit_ok;
  logic        emit_err;
  logic [1:0]  err_code;

  assign basic   = (kind_r == KIND_BASIC) || (auto_r == AUTO_BASIC);
  assign want    = basic ? cfg.basic_leader : cfg.code_leader;
  assign len_inc = sat_inc16(len_r);

  always_comb begin
    phase_nxt   = phase_r;
    sync_nxt    = sync_r;
    fstep_nxt   = fstep_r;
    kind_nxt    = kind_r;
    auto_nxt    = auto_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    namecnt_nxt = namecnt_r;
    len_nxt     = len_r;
    emit_ok     = 1'b0;
    emit_err    = 1'b0;
    err_code    = ST_FEW_SYNC;

    case (phase_r)
      PH_HUNT: begin
        if (tape_end) begin
          emit_err = 1'b1;
          err_code = ST_FEW_SYNC;
        end else if (tape_byte == SYNC_BYTE) begin
          sync_nxt = sat_inc16(sync_r);
          len_nxt  = len_inc;
        end else if (sync_r < {8'd0, cfg.min_sync}) begin
          emit_err = 1'b1;
          err_code = ST_FEW_SYNC;
        end else if (tape_byte != MARKER_BYTE) begin
          emit_err = 1'b1;
          err_code = ST_NO_MARKER;
        end else begin
          len_nxt   = len_inc;
          phase_nxt = PH_FIELDS;
          fstep_nxt = 4'd0;
        end
      end
      PH_FIELDS: begin
        if (tape_end) begin
          if (fstep_r < STEP_LAST) begin
            emit_err = 1'b1;
            err_code = ST_TRUNCATED;
          end else begin
            emit_ok = 1'b1;
          end
        end else begin
          len_nxt = len_inc;
          case (fstep_r)
            STEP_KIND:     kind_nxt  = tape_byte;
            STEP_AUTO:     auto_nxt  = tape_byte;
            STEP_END_HI:   end_nxt   = {tape_byte, 8'd0};
            STEP_END_LO:   end_nxt   = {end_r[15:8], tape_byte};
            STEP_START_HI: start_nxt = {tape_byte, 8'd0};
            STEP_START_LO: start_nxt = {start_r[15:8], tape_byte};
            default: ;
          endcase
          if (fstep_r >= STEP_LAST) begin
            phase_nxt = PH_NAME;
            fstep_nxt = 4'd0;
          end else begin
            fstep_nxt = fstep_r + 4'd1;
          end
        end
      end
      PH_NAME: begin
        if (tape_end || tape_byte == NAME_END) begin
          emit_ok = 1'b1;
        end else begin
          len_nxt     = len_inc;
          namecnt_nxt = sat_inc16(namecnt_r);
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase

    // any result sends the parser back to sync hunting
    if (emit_ok || emit_err) begin
      phase_nxt   = PH_HUNT;
      sync_nxt    = '0;
      fstep_nxt   = '0;
      kind_nxt    = '0;
      auto_nxt    = '0;
      start_nxt   = '0;
      end_nxt     = '0;
      namecnt_nxt = '0;
      len_nxt     = '0;
    end
  end

  always_comb begin
    result = '0;
    result.sync_found = sync_r;
    if (emit_err) begin
      result.status = err_code;
    end else begin
      result.status        = ST_OK;
      result.file_kind     = kind_r;
      result.autorun_flag  = auto_r;
      result.load_start    = start_r;
      result.load_end      = end_r;
      result.body_length   = {16'd0, end_r} - {16'd0, start_r} + 32'd1;
      result.leader_pad    = (sync_r < want) ? want - sync_r : 16'd0;
      result.basic_file    = basic;
      result.name_length   = namecnt_r;
      result.header_length = len_inc;
    end
  end

  assign emit = emit_ok || emit_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      sync_r    <= '0;
      fstep_r   <= '0;
      kind_r    <= '0;
      auto_r    <= '0;
      start_r   <= '0;
      end_r     <= '0;
      namecnt_r <= '0;
      len_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      sync_r    <= sync_nxt;
      fstep_r   <= fstep_nxt;
      kind_r    <= kind_nxt;
      auto_r    <= auto_nxt;
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      namecnt_r <= namecnt_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

[sv/tape_image_header_parser.sv]
// Tape image header parser. Feed the tape image one byte per transfer on
// in_bus and close it with a transfer that has tape_end set. The block counts
// the leading 0x16 sync bytes, expects the 0x24 marker, decodes the header
// fields and the zero-terminated name, and gives one result on out_bus per
// header: status ok with the decoded fields, or an error status (too few sync,
// missing marker, truncated) with only sync_found filled in. After any result
// it hunts for sync again. It takes one byte every cycle unless a result is
// stalled on out_bus; the per-byte state update in the parser core is
// combinational between the input register and the result register, and
// each result goes through the result register before it is valid. A
// stalled result holds the parser, and one more byte is still taken into the
// input register meanwhile. There is no clearing pass after reset. Write
// configuration only while idle; cfg_bus is always ready and a write to an
// unknown index is dropped.
module tape_image_header_parser (
  input  logic clk,
  input  logic rst_n,
  tihp_in_if.sink    in_bus,
  tihp_out_if.source out_bus,
  tihp_cfg_if.sink   cfg_bus
);
  import tihp_pkg::*;

  // configuration registers
  tihp_cfg_t cfg_r;

  // input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // result register
  logic        out_v_r;
  hdr_result_t out_r;

  logic        step;
  logic        emit;
  hdr_result_t result;

  // advance the parser when the result side has room for whatever it emits
  assign step         = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || step;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_sync     <= MIN_SYNC_RST;
      cfg_r.basic_leader <= BASIC_LEADER_RST;
      cfg_r.code_leader  <= CODE_LEADER_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_MIN_SYNC:     cfg_r.min_sync     <= cfg_bus.data[7:0];
        REG_BASIC_LEADER: cfg_r.basic_leader <= cfg_bus.data;
        REG_CODE_LEADER:  cfg_r.code_leader  <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // hold a byte until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.tape_byte;
      in_end_r  <= in_bus.tape_end;
    end
  end

  tihp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .tape_byte (in_byte_r),
    .tape_end  (in_end_r),
    .cfg       (cfg_r),
    .emit      (emit),
    .result    (result)
  );

  // load a new result, or drop the old one once it has been transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step && emit) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_r <= result;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.status        = out_r.status;
  assign out_bus.file_kind     = out_r.file_kind;
  assign out_bus.autorun_flag  = out_r.autorun_flag;
  assign out_bus.load_start    = out_r.load_start;
  assign out_bus.load_end      = out_r.load_end;
  assign out_bus.body_length   = out_r.body_length;
  assign out_bus.leader_pad    = out_r.leader_pad;
  assign out_bus.basic_file    = out_r.basic_file;
  assign out_bus.sync_found    = out_r.sync_found;
  assign out_bus.name_length   = out_r.name_length;
  assign out_bus.header_length = out_r.header_length;

endmodule
